### design/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types, register indexes and the grid offset helper for the glyph
// run rectangle emitter.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int GLYPH_ROWS = 8;
  localparam int ROW_W      = $clog2(GLYPH_ROWS);
  localparam logic [14:0] MAX_DIM = 15'h7fff;

  // Register indexes (word address bits [3:2])
  typedef enum logic [1:0] {
    REG_CHAR_WIDTH  = 2'd0,
    REG_CHAR_HEIGHT = 2'd1,
    REG_ADVANCE_X   = 2'd2,
    REG_ADVANCE_Y   = 2'd3
  } gre_reg_t;

  typedef struct packed {
    logic [63:0]        glyph_bits;
    logic               new_string;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
  } gre_in_t;

  typedef struct packed {
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic               last_rect;
  } gre_out_t;

  typedef struct packed {
    logic signed [15:0] char_width;
    logic signed [15:0] char_height;
    logic signed [15:0] advance_x;
    logic signed [15:0] advance_y;
  } gre_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the input beat
    logic step;       // extract one run or skip one row
    logic push_last;  // move pending rectangle out, flagged last
    logic finish;     // advance the pen
  } gre_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand_valid; // this step yields a non-empty rectangle
    logic pend_valid; // a rectangle waits for its successor
    logic out_free;   // output register can take a beat
    logic scan_end;   // this step finishes the last row
  } gre_status_t;

  // Offset of grid line idx within a cell, truncated toward zero
  function automatic logic signed [16:0] grid_off(input logic signed [15:0] size,
                                                  input logic [3:0] idx);
    logic signed [20:0] prod;
    logic signed [20:0] adj;
    prod = 21'(size) * 21'($signed({1'b0, idx}));
    adj  = prod + (prod[20] ? 21'sd7 : 21'sd0);
    return 17'(adj >>> 3);
  endfunction

endpackage

### design/gre_cfg.sv
// ----------------------------------------------------------------------------
// gre_cfg
// APB register file holding cell size and pen step.
// ----------------------------------------------------------------------------
module gre_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gre_pkg::gre_cfg_t cfg
);
  import gre_pkg::*;

  gre_cfg_t cfg_r;
  gre_reg_t idx;
  logic     wr_en;

  assign idx    = gre_reg_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.char_width  <= 16'sd16;
      cfg_r.char_height <= 16'sd32;
      cfg_r.advance_x   <= 16'sd16;
      cfg_r.advance_y   <= 16'sd0;
    end else if (wr_en) begin
      case (idx)
        REG_CHAR_WIDTH:  cfg_r.char_width  <= pwdata[15:0];
        REG_CHAR_HEIGHT: cfg_r.char_height <= pwdata[15:0];
        REG_ADVANCE_X:   cfg_r.advance_x   <= pwdata[15:0];
        REG_ADVANCE_Y:   cfg_r.advance_y   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    case (idx)
      REG_CHAR_WIDTH:  prdata = 32'(cfg_r.char_width);
      REG_CHAR_HEIGHT: prdata = 32'(cfg_r.char_height);
      REG_ADVANCE_X:   prdata = 32'(cfg_r.advance_x);
      REG_ADVANCE_Y:   prdata = 32'(cfg_r.advance_y);
      default:         prdata = 32'd0;
    endcase
  end

endmodule

### design/gre_ctrl.sv
// ----------------------------------------------------------------------------
// gre_ctrl
// Sequencer: takes a glyph, steps the run scan, flushes the final rectangle.
// ----------------------------------------------------------------------------
module gre_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gre_pkg::gre_status_t st,
  output gre_pkg::gre_cmd_t    cmd
);
  import gre_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // hold while a new rectangle would need a full output register
        cmd.step = !(st.cand_valid && st.pend_valid && !st.out_free);
        if (cmd.step && st.scan_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_last = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/gre_dp.sv
// ----------------------------------------------------------------------------
// gre_dp
// Datapath: pen, glyph and row scan registers, run extraction, edge
// arithmetic, pending rectangle and output register.
// ----------------------------------------------------------------------------
module gre_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gre_pkg::gre_cfg_t    cfg,
  input  gre_pkg::gre_in_t     in_data,
  input  gre_pkg::gre_cmd_t    cmd,
  output gre_pkg::gre_status_t st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gre_pkg::gre_out_t    out_rect
);
  import gre_pkg::*;

  logic [63:0]      glyph_r;
  logic [31:0]      pen_x_r, pen_x_nxt;
  logic [31:0]      pen_y_r, pen_y_nxt;
  logic [ROW_W-1:0] row_r, row_inc;
  logic [7:0]       rem_r, rem_clr, run_mask;
  logic             pend_valid_r, pend_valid_nxt;
  gre_out_t         pend_r;
  gre_out_t         pend_last;
  logic             out_valid_r, out_valid_nxt;
  gre_out_t         out_r;

  logic [3:0]         col_s, col_e;
  logic               found, closed;
  logic signed [16:0] xa, xb, ya, yb, xlo, ylo;
  logic signed [17:0] dx, dy;
  logic [17:0]        xmag, ymag;
  logic               out_free;
  gre_out_t           cand;

  // Locate the leftmost run of set bits still pending in this row
  always_comb begin
    found  = 1'b0;
    closed = 1'b0;
    col_s  = 4'd0;
    col_e  = 4'd8;
    for (int c = 0; c < 8; c++) begin
      if (!found && rem_r[7-c]) begin
        found = 1'b1;
        col_s = 4'(c);
      end else if (found && !closed && !rem_r[7-c]) begin
        closed = 1'b1;
        col_e  = 4'(c);
      end
    end
    for (int c = 0; c < 8; c++) begin
      run_mask[7-c] = (4'(c) >= col_s) && (4'(c) < col_e);
    end
  end

  assign rem_clr = rem_r & ~run_mask;
  assign row_inc = row_r + 1'b1;

  // Cell edges and spans
  assign ya = grid_off(cfg.char_height, {1'b0, row_r});
  assign yb = grid_off(cfg.char_height, {1'b0, row_r} + 4'd1);
  assign xa = grid_off(cfg.char_width, col_s);
  assign xb = grid_off(cfg.char_width, col_e);
  assign dx = 18'(xb) - 18'(xa);
  assign dy = 18'(yb) - 18'(ya);
  assign xlo  = dx[17] ? xb : xa;
  assign ylo  = dy[17] ? yb : ya;
  assign xmag = dx[17] ? 18'(-dx) : 18'(dx);
  assign ymag = dy[17] ? 18'(-dy) : 18'(dy);

  // Candidate rectangle for this step
  always_comb begin
    cand.rect_x    = pen_x_r + 32'(xlo);
    cand.rect_y    = pen_y_r + 32'(ylo);
    cand.rect_w    = (xmag > 18'(MAX_DIM)) ? MAX_DIM : xmag[14:0];
    cand.rect_h    = (ymag > 18'(MAX_DIM)) ? MAX_DIM : ymag[14:0];
    cand.last_rect = 1'b0;
  end

  // Pending rectangle flagged as the final one of its glyph
  always_comb begin
    pend_last           = pend_r;
    pend_last.last_rect = 1'b1;
  end

  assign out_free = !out_valid_r || !out_stall;

  assign st.cand_valid = (rem_r != 8'd0) && (xmag != 18'd0) && (ymag != 18'd0);
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free;
  assign st.scan_end   = (row_r == ROW_W'(GLYPH_ROWS - 1)) && (rem_clr == 8'd0);

  // Pen: load from start point on a new string, step after each glyph
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (cmd.load && in_data.new_string) begin
      pen_x_nxt = in_data.start_x;
      pen_y_nxt = in_data.start_y;
    end else if (cmd.finish) begin
      pen_x_nxt = pen_x_r + 32'(cfg.advance_x);
      pen_y_nxt = pen_y_r + 32'(cfg.advance_y);
    end
  end

  // Pending and output valid flags
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (cmd.step && st.cand_valid) begin
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
      end
    end
    if (cmd.push_last) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= 32'd0;
      pen_y_r      <= 32'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Scan registers and rectangle payloads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= in_data.glyph_bits;
      row_r   <= '0;
      rem_r   <= in_data.glyph_bits[7:0];
    end else if (cmd.step) begin
      if (rem_clr == 8'd0) begin
        row_r <= row_inc;
        rem_r <= glyph_r[{row_inc, 3'b000} +: 8];
      end else begin
        rem_r <= rem_clr;
      end
    end
    if (cmd.step && st.cand_valid) begin
      pend_r <= cand;
      if (pend_valid_r) begin
        out_r <= pend_r;
      end
    end
    if (cmd.push_last) begin
      out_r <= pend_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rect  = out_r;

endmodule

### design/glyph_run_rectangle_emitter_top.sv
// Flow: a new glyph is taken only once the previous one has been scanned and flushed;
// the run scan steps one run or empty row per cycle unless held by a full output register.
// Rectangles leave at most one per cycle, and only while the output is not stalled.
// Reset: synchronous active-low; registers to defaults, pen to zero, no output.
// ----------------------------------------------------------------------------
// glyph_run_rectangle_emitter_top
// Turns 8x8 glyph bitmaps into filled rectangles at a moving pen position.
// ----------------------------------------------------------------------------
module glyph_run_rectangle_emitter_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gre_pkg::gre_in_t  in_glyph,
  output logic              out_valid,
  input  logic              out_stall,
  output gre_pkg::gre_out_t out_rect,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gre_pkg::*;

  gre_cfg_t    cfg;
  gre_cmd_t    cmd;
  gre_status_t st;

  gre_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gre_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_glyph),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rect  (out_rect)
  );

endmodule

### sim/glyph_run_rectangle_emitter_top_test.sv
// ----------------------------------------------------------------------------
// glyph_run_rectangle_emitter_top_test
// Drives glyph beats and register writes into the rectangle emitter, predicts
// every rectangle from its own copy of the pen and cell settings, and checks
// each output beat in order under idle, stall and long hold-off traffic.
// ----------------------------------------------------------------------------
module glyph_run_rectangle_emitter_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gre_pkg::*;

  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int PRINT_CAP      = 20;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gre_in_t     in_glyph = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gre_out_t    out_rect;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: pen position and cell settings as the block holds them
  logic [31:0] pen_x = '0;
  logic [31:0] pen_y = '0;
  gre_cfg_t    cell_cfg = '{char_width: 16'sd16, char_height: 16'sd32,
                            advance_x: 16'sd16, advance_y: 16'sd0};

  gre_out_t    rects_due[$];
  int          glyphs_sent    = 0;
  int          rects_seen     = 0;
  int          mismatches     = 0;
  int          settings_used  = 1;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          hold_len       = 0;
  int          quiet_cycles   = 0;

  glyph_run_rectangle_emitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_glyph  (in_glyph),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rect  (out_rect),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // Grid line offset within a cell; integer division truncates toward zero
  function automatic int cell_line(input int size, input int idx);
    return (size * idx) / 8;
  endfunction

  // Order two edges: return the span and the lower edge
  function automatic int edge_span(input int a, input int b, output int lo);
    if (b < a) begin
      lo = b;
      return a - b;
    end
    lo = a;
    return b - a;
  endfunction

  function automatic logic [14:0] clamp_dim(input int d);
    return (d > 32767) ? MAX_DIM : d[14:0];
  endfunction

  // Work out every rectangle of one glyph and move the pen on
  task automatic plot_glyph(input gre_in_t g);
    gre_out_t   rects[$];
    gre_out_t   r;
    logic [7:0] row_bits;
    int cw, ch, adv_x, adv_y, row, col, first_col, ylo, ht, xlo, wd;
    cw    = $signed(cell_cfg.char_width);
    ch    = $signed(cell_cfg.char_height);
    adv_x = $signed(cell_cfg.advance_x);
    adv_y = $signed(cell_cfg.advance_y);
    if (g.new_string) begin
      pen_x = g.start_x;
      pen_y = g.start_y;
    end
    if (cw != 0 && ch != 0) begin
      for (row = 0; row < GLYPH_ROWS; row++) begin
        row_bits = g.glyph_bits[8*row +: 8];
        if (row_bits == 8'h00) continue;
        ht = edge_span(cell_line(ch, row), cell_line(ch, row + 1), ylo);
        if (ht == 0) continue;
        col = 0;
        // Scan runs left to right; bit 7 is column 0
        while (col < 8) begin
          while (col < 8 && !row_bits[7-col]) col++;
          if (col == 8) break;
          first_col = col;
          while (col < 8 && row_bits[7-col]) col++;
          wd = edge_span(cell_line(cw, first_col), cell_line(cw, col), xlo);
          if (wd == 0) continue;
          r.rect_x    = pen_x + xlo;
          r.rect_y    = pen_y + ylo;
          r.rect_w    = clamp_dim(wd);
          r.rect_h    = clamp_dim(ht);
          r.last_rect = 1'b0;
          rects.push_back(r);
        end
      end
    end
    if (rects.size() > 0) rects[rects.size()-1].last_rect = 1'b1;
    foreach (rects[i]) rects_due.push_back(rects[i]);
    pen_x = pen_x + adv_x;
    pen_y = pen_y + adv_y;
  endtask

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("rectangle %0d %s: got %0d, wanted %0d",
                                rects_seen, name, got, want));
  endtask

  // Compare each accepted rectangle beat with the oldest prediction
  always @(posedge clk) begin
    gre_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rects_due.size() == 0) begin
        report_mismatch($sformatf("rectangle %0d arrived with none outstanding",
                                  rects_seen));
      end else begin
        want = rects_due.pop_front();
        check_field("rect_x", out_rect.rect_x, want.rect_x);
        check_field("rect_y", out_rect.rect_y, want.rect_y);
        check_field("rect_w", out_rect.rect_w, want.rect_w);
        check_field("rect_h", out_rect.rect_h, want.rect_h);
        check_field("last_rect", out_rect.last_rect, want.last_rect);
      end
      rects_seen++;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: give up after a long stretch with no beat on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("glyph_run_rectangle_emitter_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ drivers

  // Offer one glyph beat after a random gap and predict it once taken
  task automatic send_glyph(input gre_in_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_glyph <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plot_glyph(g);
    glyphs_sent++;
  endtask

  // Drop valid, wait for every rectangle, then let a blank glyph finish
  task automatic settle();
    in_valid <= 1'b0;
    while (rects_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, read it back, and mirror it in the predictor
  task automatic cfg_write(input gre_reg_t idx, input logic signed [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back from the same address
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value)
      report_mismatch($sformatf("register %s read %h, wrote %h",
                                idx.name(), prdata[15:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHAR_WIDTH:  cell_cfg.char_width  = value;
      REG_CHAR_HEIGHT: cell_cfg.char_height = value;
      REG_ADVANCE_X:   cell_cfg.advance_x   = value;
      REG_ADVANCE_Y:   cell_cfg.advance_y   = value;
      default: ;
    endcase
  endtask

  task automatic set_cell(input logic signed [15:0] cw, input logic signed [15:0] ch,
                          input logic signed [15:0] ax, input logic signed [15:0] ay);
    cfg_write(REG_CHAR_WIDTH, cw);
    cfg_write(REG_CHAR_HEIGHT, ch);
    cfg_write(REG_ADVANCE_X, ax);
    cfg_write(REG_ADVANCE_Y, ay);
    settings_used++;
  endtask

  // --------------------------------------------------------- random stimulus

  // Cell sizes lean on the extremes, tiny cells and zero
  function automatic logic signed [15:0] pick_size();
    case ($urandom_range(9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return 16'($urandom_range(16)) - 16'sd8;
      4, 5:    return 16'($urandom_range(128)) - 16'sd64;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff - $urandom_range(100);
      1:       return 32'h8000_0000 + $urandom_range(100);
      default: return $urandom;
    endcase
  endfunction

  function automatic gre_in_t random_glyph();
    gre_in_t    g;
    logic [7:0] row;
    row          = 8'($urandom);
    g.glyph_bits = {$urandom, $urandom};
    case ($urandom_range(5))
      0: g.glyph_bits &= {$urandom, $urandom};              // sparse
      1: g.glyph_bits |= {$urandom, $urandom};              // dense
      2: g.glyph_bits = {8{row}};                           // one row repeated
      3: g.glyph_bits &= ~(64'hff << (8 * $urandom_range(7))); // a blank row
      default: ;
    endcase
    if ($urandom_range(19) == 0) g.glyph_bits = '0;
    g.new_string = ($urandom_range(7) == 0);
    g.start_x    = pick_coord();
    g.start_y    = pick_coord();
    return g;
  endfunction

  // -------------------------------------------------------------------- tests

  // Reset cell: full, blank, alternating columns, coordinate wrap at the pen
  task automatic test_default_cell();
    settle();
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b1, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'h0, 1'b0, 32'sd5, 32'sd5});
    send_glyph(gre_in_t'{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'h5555_5555_5555_5555, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'h8001_8001_8001_8001, 1'b1,
                         32'sh7fff_ffff, 32'sh7fff_ffff});
    send_glyph(gre_in_t'{64'h0100_0000_0000_0080, 1'b1,
                         32'sh8000_0000, 32'sh8000_0000});
  endtask

  // Zero width, then zero height: no rectangles but the pen still moves
  task automatic test_zero_cell();
    settle();
    set_cell(16'sd0, 16'sd32, 16'sd7, -16'sd3);
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 32'sd0, 32'sd0});
    settle();
    set_cell(16'sd16, 16'sd0, 16'sd7, -16'sd3);
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'h1818_1818_1818_1818, 1'b0, 32'sd0, 32'sd0});
  endtask

  // Most negative cell: swapped edges and a full-row width that saturates
  task automatic test_negative_cell();
    settle();
    set_cell(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b1, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'hf0f0_0f0f_f0f0_0f0f, 1'b1, -32'sd1, -32'sd1});
  endtask

  // Cells smaller than the grid: single columns and rows collapse and drop
  task automatic test_tiny_cell();
    settle();
    set_cell(16'sd3, -16'sd5, -16'sd1, 16'sd1);
    send_glyph(gre_in_t'{64'haaaa_aaaa_aaaa_aaaa, 1'b1, 32'sd100, 32'sd100});
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b0, 32'sd0, 32'sd0});
    send_glyph(gre_in_t'{64'h5a5a_c3c3_2424_8181, 1'b0, 32'sd0, 32'sd0});
  endtask

  // Largest positive cell with the most negative and most positive advances
  task automatic test_wide_cell();
    settle();
    set_cell(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
    send_glyph(gre_in_t'{64'hffff_ffff_ffff_ffff, 1'b1,
                         32'sh7fff_0000, 32'sh8000_0100});
    send_glyph(gre_in_t'{64'hc3c3_c3c3_c3c3_c3c3, 1'b0, 32'sd0, 32'sd0});
  endtask

  // Random glyphs under one idle and stall mix, two random cell settings
  task automatic test_random_traffic(input int idle_pct, input int stall, input int items);
    settle();
    stall_pct     <= stall;
    send_idle_pct  = idle_pct;
    repeat (2) begin
      settle();
      set_cell(pick_size(), pick_size(), pick_size(), pick_size());
      repeat (items) send_glyph(random_glyph());
    end
  endtask

  // Hold the output off while dense glyphs keep coming, so the input stalls
  task automatic test_input_backpressure();
    settle();
    set_cell(16'sd16, 16'sd32, 16'sd16, 16'sd0);
    stall_pct     <= 0;
    hold_len      <= HOLD_OFF_LEN;
    send_idle_pct  = 0;
    repeat (30)
      send_glyph(gre_in_t'{{$urandom, $urandom} | {$urandom, $urandom}, 1'b0,
                           32'sd0, 32'sd0});
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_cell();
    test_zero_cell();
    test_negative_cell();
    test_tiny_cell();
    test_wide_cell();
    test_random_traffic(0, 0, 52);
    test_random_traffic(78, 0, 52);
    test_random_traffic(0, 78, 52);
    test_random_traffic(28, 28, 52);
    test_input_backpressure();
    settle();

    $display("Covered %0d glyphs and %0d rectangles over %0d cell settings.",
             glyphs_sent, rects_seen, settings_used);
    $display("Included zero, negative and saturating cells, pen wrap and a long hold-off.");
    if (mismatches == 0) begin
      $display("glyph_run_rectangle_emitter_top test passed");
    end else begin
      $display("glyph_run_rectangle_emitter_top test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/gre_pkg.sv
design/gre_cfg.sv
design/gre_ctrl.sv
design/gre_dp.sv
design/glyph_run_rectangle_emitter_top.sv
sim/glyph_run_rectangle_emitter_top_test.sv
